// ===== rtl/iadc_pkg.sv =====
// Shared constants, register codes and types of the interleaved adaptive delta codec.
package iadc_pkg;

	localparam int MAX_LANES  = 8;
	localparam int LANE_W     = $clog2(MAX_LANES);
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 4;
	localparam int SHIFT_W    = 4;
	localparam int WEIGHT_W   = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CNT_W-1:0]           MAX_LANE_CNT    = CNT_W'(MAX_LANES);
	localparam logic signed [WEIGHT_W:0]   WEIGHT_LIMIT    = (WEIGHT_W+1)'(1280);
	localparam logic [BYTE_W-1:0]          RESIDUAL_MID    = BYTE_W'(127);
	localparam logic [CNT_W-1:0]           LANE_COUNT_INIT = CNT_W'(1);
	localparam logic [SHIFT_W-1:0]         RATE_SHIFT_INIT = SHIFT_W'(6);

	localparam logic DIR_ENCODE   = 1'b0;
	localparam logic DIR_DECODE   = 1'b1;
	localparam logic METHOD_DELTA = 1'b0;
	localparam logic METHOD_ADAPT = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIRECTION  = 2'd0,
		CFG_METHOD     = 2'd1,
		CFG_LANE_COUNT = 2'd2,
		CFG_RATE_SHIFT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic               direction;
		logic               method;
		logic [CNT_W-1:0]   lane_count;
		logic [SHIFT_W-1:0] rate_shift;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [LANE_W-1:0] lane;
	} result_t;

endpackage

// ===== rtl/iadc_in_if.sv =====
// Input byte channel of the codec.
interface iadc_in_if import iadc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

// ===== rtl/iadc_out_if.sv =====
// Output byte channel of the codec.
interface iadc_out_if import iadc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic [LANE_W-1:0] lane;

	modport source(output valid, output out_byte, output lane, input ready);
	modport sink(input valid, input out_byte, input lane, output ready);
endinterface

// ===== rtl/iadc_predictor.sv =====
// Per-lane history, shared weight, lane counter and the coding arithmetic.
module iadc_predictor import iadc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              step,
	input  logic [BYTE_W-1:0] in_byte,
	output result_t           result
);

	logic [BYTE_W-1:0]          hist_q [MAX_LANES];
	logic [BYTE_W-1:0]          p1_q   [MAX_LANES];
	logic [BYTE_W-1:0]          p2_q   [MAX_LANES];
	logic signed [WEIGHT_W-1:0] weight_q;
	logic [LANE_W-1:0]          lane_ctr_q;

	logic [CNT_W-1:0]           cnt;
	logic [CNT_W-1:0]           ln_ext;
	logic [LANE_W-1:0]          ln;
	logic                       pass;
	logic signed [WEIGHT_W-1:0] w_sh;
	logic [BYTE_W-1:0]          w8;
	logic [BYTE_W-1:0]          dres;
	logic [BYTE_W-1:0]          p1;
	logic [BYTE_W-1:0]          p2;
	logic [BYTE_W-1:0]          pred;
	logic [BYTE_W-1:0]          s;
	logic [BYTE_W-1:0]          upd;
	logic [BYTE_W-1:0]          sample;
	logic signed [WEIGHT_W:0]   wsum;
	logic signed [WEIGHT_W-1:0] wnext;

	always_comb begin
		cnt    = (cfg.lane_count > MAX_LANE_CNT) ? MAX_LANE_CNT : cfg.lane_count;
		pass   = (cnt == '0);
		ln_ext = CNT_W'(lane_ctr_q) + CNT_W'(1);
		ln     = (ln_ext >= cnt) ? '0 : ln_ext[LANE_W-1:0];

		w_sh = weight_q >>> cfg.rate_shift;
		w8   = w_sh[BYTE_W-1:0];

		dres = hist_q[ln] - in_byte;
		p1   = p1_q[ln];
		p2   = p2_q[ln];
		pred = (p1 - p2) + p1;
		s    = w8 + (pred - in_byte);

		upd    = (cfg.direction == DIR_DECODE) ? in_byte : s;
		sample = (cfg.direction == DIR_DECODE) ? s : in_byte;

		wsum = (WEIGHT_W+1)'(weight_q);
		if (upd < RESIDUAL_MID)
			wsum = wsum + (WEIGHT_W+1)'(1);
		else if (upd > RESIDUAL_MID)
			wsum = wsum - (WEIGHT_W+1)'(1);
		if (wsum > WEIGHT_LIMIT)
			wsum = WEIGHT_LIMIT;
		else if (wsum < -WEIGHT_LIMIT)
			wsum = -WEIGHT_LIMIT;
		wnext = wsum[WEIGHT_W-1:0];

		if (pass) begin
			result.out_byte = in_byte;
			result.lane     = '0;
		end else begin
			result.out_byte = (cfg.method == METHOD_ADAPT) ? s : dres;
			result.lane     = ln;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_LANES; k++) begin
				hist_q[k] <= '0;
				p1_q[k]   <= '0;
				p2_q[k]   <= '0;
			end
			weight_q   <= '0;
			lane_ctr_q <= '0;
		end else if (step && !pass) begin
			lane_ctr_q <= ln;
			if (cfg.method == METHOD_DELTA) begin
				hist_q[ln] <= (cfg.direction == DIR_DECODE) ? dres : in_byte;
			end else begin
				p2_q[ln] <= p1;
				p1_q[ln] <= w8 + sample;
				weight_q <= wnext;
			end
		end
	end

endmodule

// ===== rtl/interleaved_adaptive_delta_codec_top.sv =====
// Top level of the interleaved adaptive delta codec: config registers, input and output stages.
//
//  channel | dir | payload                    | handshake
//  in_ch   | in  | in_byte[7:0]               | valid / ready
//  out_ch  | out | out_byte[7:0], lane[2:0]   | valid / ready
//  cfg     | in  | cfg_index[1:0], cfg_data   | cfg_we, no back-pressure
//
// One byte per cycle while out_ch.ready is high; beats pass s1, then the output register.
// Stage s1 holds the accepted byte; lane state, and in adaptive mode the weight, update as it
// moves to the output register, so the byte entering s1 at that edge already sees new history.
// A stalled output register holds s1, and in_ch.ready drops only when both are full.
// Reset clears all lane history, the weight and the lane counter at once.
module interleaved_adaptive_delta_codec_top import iadc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	iadc_in_if.sink               in_ch,
	iadc_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	result_t           out_q;
	result_t           result;
	logic              advance;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction  <= DIR_ENCODE;
			cfg_q.method     <= METHOD_DELTA;
			cfg_q.lane_count <= LANE_COUNT_INIT;
			cfg_q.rate_shift <= RATE_SHIFT_INIT;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DIRECTION:  cfg_q.direction  <= cfg_data[0];
				CFG_METHOD:     cfg_q.method     <= cfg_data[0];
				CFG_LANE_COUNT: cfg_q.lane_count <= cfg_data[CNT_W-1:0];
				CFG_RATE_SHIFT: cfg_q.rate_shift <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid)
			byte_s1 <= in_ch.in_byte;
	end

	iadc_predictor u_predictor (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.step    (advance),
		.in_byte (byte_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ch.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= result;
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_q.out_byte;
	assign out_ch.lane     = out_q.lane;

endmodule

// ===== rtl/iadc_checker.sv =====
// Port-level checks of the codec top level and the bind that attaches them.
module iadc_checker import iadc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [BYTE_W-1:0]     out_byte,
	input logic [LANE_W-1:0]     out_lane,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	logic [1:0]       occ_q;
	logic [CNT_W-1:0] lane_count_q;
	logic             in_beat;
	logic             out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q        <= '0;
			lane_count_q <= LANE_COUNT_INIT;
		end else begin
			occ_q <= occ_q + 2'(in_beat) - 2'(out_beat);
			if (cfg_we && cfg_idx_t'(cfg_index) == CFG_LANE_COUNT)
				lane_count_q <= cfg_data[CNT_W-1:0];
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_lane))
		else $error("output beat changed while stalled");

	// at most two bytes in flight, and never a result without a byte
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q != 2'd3 && (!out_valid || occ_q != 2'd0))
		else $error("in-flight byte count out of range");

	// downstream ready always frees the input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is ready");

	// lane is zero or stays below the configured lane count
	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_lane == '0 || CNT_W'(out_lane) < lane_count_q)
		else $error("lane outside configured lane count");

endmodule

bind interleaved_adaptive_delta_codec_top iadc_checker u_iadc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.out_lane  (out_ch.lane),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);
